// ===== rtl/etp_pkg.sv =====
// Shared constants and types of the exclusive-time profiler.
package etp_pkg;

  // Default sizes of the function table and of the call stack
  localparam int DEF_NUM_FUNCS   = 256;
  localparam int DEF_STACK_DEPTH = 64;

  // Field widths
  localparam int ID_W   = 8;
  localparam int TIME_W = 32;
  localparam int UNIT_W = TIME_W + 1;
  localparam int ID_NUM = 2 ** ID_W;

  // Transaction modes
  localparam logic [1:0] MODE_ENTER = 2'd0;
  localparam logic [1:0] MODE_EXIT  = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // Result error codes
  localparam logic [1:0] ERR_OK        = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
  localparam logic [1:0] ERR_UNDERFLOW = 2'd2;
  localparam logic [1:0] ERR_BACKWARD  = 2'd3;

  // Decoded transaction handed from the stack stage to the accumulate stage
  typedef struct packed {
    logic              valid;
    logic              credit;
    logic              rd_tot;
    logic [1:0]        err;
    logic [ID_W-1:0]   id;
    logic [UNIT_W-1:0] amount;
  } etp_op_t;

endpackage

// ===== rtl/exclusive_time_profiler_unit.sv =====
// Top level of the exclusive-time profiler.
// Enter, exit and read transactions come in on the input channel and each
// returns exactly one result. A transaction moves through three registered
// stages (stack check and push, stack-top read, totals read-modify-write);
// one transaction can be accepted every cycle, limited by the output stall
// and by the totals clear after reset. The totals RAM writes back in the
// last stage and a same-entry read issued in the same cycle is served from
// the value being written. After reset the block sweeps the totals RAM to
// zero, one entry per cycle, and holds in_stall high until the sweep ends.
// Ids are reduced modulo NUM_FUNCS; timestamps must not run backward.
module exclusive_time_profiler_unit import etp_pkg::*; #(
  parameter int NUM_FUNCS   = DEF_NUM_FUNCS,
  parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        mode,
  input  logic [ID_W-1:0]   func_id,
  input  logic [TIME_W-1:0] event_time,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              credited,
  output logic [ID_W-1:0]   credited_id,
  output logic [TIME_W-1:0] total_time,
  output logic [1:0]        error_code
);

  localparam int SAW = $clog2(STACK_DEPTH);

  etp_op_t         op;
  logic            take;
  logic            busy;
  logic            stk_wr_en;
  logic [SAW-1:0]  stk_wr_addr;
  logic [ID_W-1:0] stk_wr_data;
  logic            stk_rd_en;
  logic [SAW-1:0]  stk_rd_addr;
  logic [ID_W-1:0] stack_top;

  // Check events and keep stack depth and time mark
  etp_front #(
    .NUM_FUNCS   (NUM_FUNCS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .func_id     (func_id),
    .event_time  (event_time),
    .busy        (busy),
    .take        (take),
    .op          (op),
    .stk_wr_en   (stk_wr_en),
    .stk_wr_addr (stk_wr_addr),
    .stk_wr_data (stk_wr_data),
    .stk_rd_en   (stk_rd_en),
    .stk_rd_addr (stk_rd_addr)
  );

  // Call stack of reduced ids
  etp_ram #(
    .WIDTH (ID_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (stk_wr_en),
    .wr_addr (stk_wr_addr),
    .wr_data (stk_wr_data),
    .rd_en   (stk_rd_en),
    .rd_addr (stk_rd_addr),
    .rd_data (stack_top)
  );

  // Update totals and register the result
  etp_accum #(
    .NUM_FUNCS (NUM_FUNCS)
  ) u_accum (
    .clk         (clk),
    .rst         (rst),
    .op          (op),
    .stack_top   (stack_top),
    .take        (take),
    .busy        (busy),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .credited    (credited),
    .credited_id (credited_id),
    .total_time  (total_time),
    .error_code  (error_code)
  );

`ifndef SYNTHESIS
  // No transaction enters while the totals are being cleared
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    busy |-> in_stall)
    else $error("transaction accepted during totals clear");

  // A credited result carries no error
  a_credit_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && credited) |-> (error_code == ERR_OK))
    else $error("credited result with an error code");

  // Every credit adds at least one unit, so the new total is never zero
  a_credit_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && credited) |-> (total_time != '0))
    else $error("credited result with a zero total");
`endif

endmodule

// ===== rtl/etp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module etp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/etp_front.sv =====
// Stack stage: checks each event, tracks stack depth and time, pushes ids.
module etp_front import etp_pkg::*; #(
  parameter int NUM_FUNCS   = DEF_NUM_FUNCS,
  parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     mode,
  input  logic [ID_W-1:0]                func_id,
  input  logic [TIME_W-1:0]              event_time,
  input  logic                           busy,
  input  logic                           take,
  output etp_op_t                        op,
  output logic                           stk_wr_en,
  output logic [$clog2(STACK_DEPTH)-1:0] stk_wr_addr,
  output logic [ID_W-1:0]                stk_wr_data,
  output logic                           stk_rd_en,
  output logic [$clog2(STACK_DEPTH)-1:0] stk_rd_addr
);

  localparam int SAW   = $clog2(STACK_DEPTH);
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  // Build the id reduction table at elaboration
  function automatic logic [ID_NUM*ID_W-1:0] build_wrap();
    logic [ID_NUM*ID_W-1:0] tbl;
    tbl = '0;
    for (int i = 0; i < ID_NUM; i++) begin
      tbl[i*ID_W +: ID_W] = ID_W'(i % NUM_FUNCS);
    end
    return tbl;
  endfunction

  localparam logic [ID_NUM*ID_W-1:0] WRAP_TBL = build_wrap();

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [CNT_W-1:0]  cnt_dec;
  logic [UNIT_W-1:0] next_unit;
  logic [UNIT_W-1:0] next_unit_next;
  logic [UNIT_W-1:0] t_ext;
  logic [ID_W-1:0]   wid;
  logic              adv;
  logic              accept;
  logic              backward;
  logic              full;
  logic              push;
  etp_op_t           op_next;

  assign adv      = !op.valid || take;
  assign accept   = in_valid && adv && !busy;
  assign in_stall = !adv || busy;

  assign t_ext    = {1'b0, event_time};
  assign backward = t_ext < next_unit;
  assign full     = count == CNT_W'(STACK_DEPTH);
  assign cnt_dec  = count - CNT_W'(1);
  assign wid      = WRAP_TBL[int'(func_id)*ID_W +: ID_W];

  // Decide the outcome of the transaction and the new stack and time state
  always_comb begin
    op_next        = '0;
    op_next.valid  = accept;
    count_next     = count;
    next_unit_next = next_unit;
    push           = 1'b0;
    unique case (mode)
      MODE_ENTER: begin
        if (backward) begin
          op_next.err = ERR_BACKWARD;
        end else if (full) begin
          op_next.err = ERR_OVERFLOW;
        end else begin
          op_next.credit = (count != '0) && (t_ext != next_unit);
          op_next.amount = t_ext - next_unit;
          next_unit_next = t_ext;
          count_next     = count + CNT_W'(1);
          push           = 1'b1;
        end
      end
      MODE_EXIT: begin
        if (backward) begin
          op_next.err = ERR_BACKWARD;
        end else if (count == '0) begin
          op_next.err = ERR_UNDERFLOW;
        end else begin
          op_next.credit = 1'b1;
          op_next.amount = t_ext + UNIT_W'(1) - next_unit;
          next_unit_next = t_ext + UNIT_W'(1);
          count_next     = cnt_dec;
        end
      end
      MODE_READ: begin
        op_next.rd_tot = 1'b1;
        op_next.id     = wid;
      end
      default: begin
        op_next.err = ERR_OK;
      end
    endcase
  end

  // Push at the current depth; read the top one below it
  assign stk_wr_en   = accept && push;
  assign stk_wr_addr = count[SAW-1:0];
  assign stk_wr_data = wid;
  assign stk_rd_en   = adv;
  assign stk_rd_addr = cnt_dec[SAW-1:0];

  // Hold stack depth, time mark and the decoded transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      next_unit <= '0;
      op.valid  <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        next_unit <= next_unit_next;
      end
      if (adv) begin
        op <= op_next;
      end
    end
  end

endmodule

// ===== rtl/etp_accum.sv =====
// Accumulate stage: read-modify-write of the per-function totals and result register.
module etp_accum import etp_pkg::*; #(
  parameter int NUM_FUNCS = DEF_NUM_FUNCS
) (
  input  logic              clk,
  input  logic              rst,
  input  etp_op_t           op,
  input  logic [ID_W-1:0]   stack_top,
  output logic              take,
  output logic              busy,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              credited,
  output logic [ID_W-1:0]   credited_id,
  output logic [TIME_W-1:0] total_time,
  output logic [1:0]        error_code
);

  localparam int AW = $clog2(NUM_FUNCS);

  etp_op_t           s2;
  logic [ID_W-1:0]   s2_id;
  logic [ID_W-1:0]   rd_id;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     clr_addr;
  logic [AW-1:0]     wr_addr;
  logic [TIME_W-1:0] wr_data;
  logic [TIME_W-1:0] tot_rd;
  logic [TIME_W-1:0] base;
  logic [TIME_W-1:0] sat;
  logic [TIME_W-1:0] fwd_val;
  logic [TIME_W+1:0] sum;
  logic              fwd_hit;
  logic              item_wr;
  logic              wr_en;
  logic              en_out;

  assign en_out = !out_valid || !out_stall;
  assign take   = !s2.valid || en_out;

  // Address totals by the read id or by the stack top
  assign rd_id   = op.rd_tot ? op.id : stack_top;
  assign rd_addr = AW'(rd_id);

  // Add credit to the old total, taking the value in flight on a same-entry hit
  assign base = fwd_hit ? fwd_val : tot_rd;
  assign sum  = {2'b00, base} + {1'b0, s2.amount};
  assign sat  = (sum[TIME_W+1:TIME_W] != 2'b00) ? '1 : sum[TIME_W-1:0];

  // Clear pass after reset, then write back credited totals
  assign item_wr = s2.valid && s2.credit && en_out;
  assign wr_en   = busy || item_wr;
  assign wr_addr = busy ? clr_addr : AW'(s2_id);
  assign wr_data = busy ? '0 : sat;

  etp_ram #(
    .WIDTH (TIME_W),
    .DEPTH (NUM_FUNCS)
  ) u_totals (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (take),
    .rd_addr (rd_addr),
    .rd_data (tot_rd)
  );

  // Advance the clear pointer until the table is swept
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(NUM_FUNCS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Load the accumulate stage and note a write to the entry being read
  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else if (take) begin
      s2      <= op;
      s2_id   <= rd_id;
      fwd_hit <= item_wr && (AW'(s2_id) == rd_addr);
      fwd_val <= sat;
    end
  end

  // Hold the result until the transaction is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en_out) begin
      out_valid <= s2.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      credited    <= s2.credit;
      credited_id <= (s2.credit || s2.rd_tot) ? s2_id : '0;
      total_time  <= s2.credit ? sat : (s2.rd_tot ? base : '0);
      error_code  <= s2.err;
    end
  end

endmodule
